// ===== rtl/core/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer with peek and drop.
// ----------------------------------------------------------------------------
package brb_pkg;

	// Fixed field widths of the command and result items.
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned CNT_W  = 13;

	// Default size of the ring in bytes.
	localparam int unsigned DEPTH_DEFAULT = 4096;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_DROP  = 2'd3
	} cmd_t;

	// Status of the result stage handed from control to the top level.
	typedef struct packed {
		logic vld;
		logic rd_ok;
	} res_ctl_t;

endpackage

// ===== rtl/core/brb_mem.sv =====
// ----------------------------------------------------------------------------
// brb_mem
// Byte store of the ring: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module brb_mem
	import brb_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEFAULT,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [PW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [PW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with the data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/brb_ctrl.sv =====
// ----------------------------------------------------------------------------
// brb_ctrl
// Command register, pointer and fill count state, and the result register.
// ----------------------------------------------------------------------------
module brb_ctrl
	import brb_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEFAULT,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [CMD_W-1:0]  command,
	input  logic [DATA_W-1:0] data_in,
	input  logic [CNT_W-1:0]  amount,
	output logic              mem_we,
	output logic [PW-1:0]     mem_waddr,
	output logic [DATA_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [PW-1:0]     mem_raddr,
	output res_ctl_t          res_ctl,
	output logic [CNT_W-1:0]  done_res,
	output logic [CNT_W-1:0]  readable,
	output logic [CNT_W-1:0]  writable
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned WW = (CW > CNT_W) ? CW : CNT_W;
	localparam int unsigned SW = PW + 1;

	// Input register.
	logic              vld_s1;
	cmd_t              cmd_s1;
	logic [DATA_W-1:0] din_s1;
	logic [CNT_W-1:0]  amt_s1;

	// Ring state.
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	// Next state and result values.
	logic [PW-1:0] wp_d;
	logic [PW-1:0] rp_d;
	logic [CW-1:0] cnt_d;
	logic [CW-1:0] done_d;
	logic          rd_ok_d;
	logic [CW-1:0] free_d;

	logic [WW-1:0] amt_x;
	logic [WW-1:0] held_x;
	logic          amt_ok;
	logic [CW-1:0] drop_n;
	logic [SW-1:0] drop_sum;
	logic [SW-1:0] peek_sum;
	logic [PW-1:0] drop_ptr;
	logic [PW-1:0] peek_ptr;
	logic [PW-1:0] wp_inc;
	logic [PW-1:0] rp_inc;
	logic          full;
	logic [WW-1:0] done_x;
	logic [WW-1:0] rd_x;
	logic [WW-1:0] wr_x;

	// Result register.
	logic             vld_s2;
	logic             rd_ok_s2;
	logic [CNT_W-1:0] done_s2;
	logic [CNT_W-1:0] readable_s2;
	logic [CNT_W-1:0] writable_s2;

	// Capture a command when it is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(command);
			din_s1 <= data_in;
			amt_s1 <= amount;
		end
	end

	// Offset and drop count against the bytes held.
	always_comb begin
		amt_x    = WW'(amt_s1);
		held_x   = WW'(cnt_q);
		amt_ok   = amt_x < held_x;
		drop_n   = amt_ok ? CW'(amt_x) : cnt_q;
		full     = cnt_q == CW'(DEPTH);
	end

	// Pointer arithmetic; the drop sum, and the peek sum when the offset is in range, stay below twice the ring size.
	always_comb begin
		drop_sum = SW'(rp_q) + SW'(drop_n);
		peek_sum = SW'(rp_q) + SW'(amt_x);
		drop_ptr = (drop_sum >= SW'(DEPTH)) ? PW'(drop_sum - SW'(DEPTH)) : PW'(drop_sum);
		peek_ptr = (peek_sum >= SW'(DEPTH)) ? PW'(peek_sum - SW'(DEPTH)) : PW'(peek_sum);
		wp_inc   = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
		rp_inc   = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
	end

	// Command decode: next state, store access and result values.
	always_comb begin
		wp_d      = wp_q;
		rp_d      = rp_q;
		cnt_d     = cnt_q;
		done_d    = '0;
		rd_ok_d   = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rp_q;
		if (vld_s1) begin
			case (cmd_s1)
				CMD_WRITE: begin
					if (!full) begin
						mem_we = 1'b1;
						wp_d   = wp_inc;
						cnt_d  = cnt_q + CW'(1);
						done_d = CW'(1);
					end
				end
				CMD_READ: begin
					if (cnt_q != '0) begin
						mem_re  = 1'b1;
						rp_d    = rp_inc;
						cnt_d   = cnt_q - CW'(1);
						done_d  = CW'(1);
						rd_ok_d = 1'b1;
					end
				end
				CMD_PEEK: begin
					if (amt_ok) begin
						mem_re    = 1'b1;
						mem_raddr = peek_ptr;
						done_d    = CW'(1);
						rd_ok_d   = 1'b1;
					end
				end
				CMD_DROP: begin
					rp_d   = drop_ptr;
					cnt_d  = cnt_q - drop_n;
					done_d = drop_n;
				end
				default: begin
					done_d = '0;
				end
			endcase
		end
		free_d = CW'(DEPTH) - cnt_d;
	end

	assign mem_waddr = wp_q;
	assign mem_wdata = din_s1;

	// Counts are reported in the low bits of the result fields.
	always_comb begin
		done_x = WW'(done_d);
		rd_x   = WW'(cnt_d);
		wr_x   = WW'(free_d);
	end

	// Ring state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_d;
			rp_q  <= rp_d;
			cnt_q <= cnt_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			rd_ok_s2 <= 1'b0;
		end else begin
			vld_s2   <= vld_s1;
			rd_ok_s2 <= rd_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			done_s2     <= done_x[CNT_W-1:0];
			readable_s2 <= rd_x[CNT_W-1:0];
			writable_s2 <= wr_x[CNT_W-1:0];
		end
	end

	assign res_ctl.vld   = vld_s2;
	assign res_ctl.rd_ok = rd_ok_s2;
	assign done_res      = done_s2;
	assign readable      = readable_s2;
	assign writable      = writable_s2;

endmodule

// ===== rtl/core/byte_ring_buffer_with_peek_drop_top.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_peek_drop_top
// Byte FIFO on a ring store with write, read, peek-at-offset and drop commands.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  command   start / busy     command, data_in, amount
//  result    strobe           data_out, done_res, readable, writable
//
// An item accepted at one edge is held in the command register, where the
// pointers, the fill count and the store port are updated; its result is
// shown in the cycle after that, from the result register.
// busy never rises, so a new item can be taken every cycle.
// The result is valid for one cycle only; the receiver cannot stall it.
// Reset empties the ring; the store contents are left as they are.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_peek_drop_top
	import brb_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  command,
	input  logic [DATA_W-1:0] data_in,
	input  logic [CNT_W-1:0]  amount,
	output logic              strobe,
	output logic [DATA_W-1:0] data_out,
	output logic [CNT_W-1:0]  done_res,
	output logic [CNT_W-1:0]  readable,
	output logic [CNT_W-1:0]  writable
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              accept;
	logic              mem_we;
	logic [PW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [PW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	res_ctl_t          res_ctl;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Command decode and ring state.
	brb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.data_in  (data_in),
		.amount   (amount),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.res_ctl  (res_ctl),
		.done_res (done_res),
		.readable (readable),
		.writable (writable)
	);

	// Byte store.
	brb_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// A byte is shown only for a read or peek that found data.
	assign strobe   = res_ctl.vld;
	assign data_out = res_ctl.rd_ok ? mem_rdata : '0;

	// Every accepted item yields exactly one result, after the command and result registers.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 strobe)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ##1 !strobe)
		else $error("result without an accepted item");

	// Held and free bytes always add up to the ring size.
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (CNT_W'(readable + writable) == CNT_W'(DEPTH)))
		else $error("readable and writable do not sum to the ring size");

	// A nonzero byte only comes out of a read or peek that succeeded.
	a_data_done: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (data_out != '0)) |-> (done_res == CNT_W'(1)))
		else $error("data returned without a completed read or peek");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring buffer with peek and drop. The bench
// keeps its own copy of the ring and predicts each result as commands are
// taken. Directed commands cover the empty ring, the full ring and pointer
// wrap. Random bursts with random gaps follow.
// ----------------------------------------------------------------------------
module testbench;
	import brb_pkg::*;

	localparam int unsigned RING_BYTES    = DEPTH_DEFAULT;
	localparam int unsigned RING_AW       = $clog2(RING_BYTES);
	localparam int unsigned MAX_AMOUNT    = (1 << CNT_W) - 1;
	localparam int unsigned RANDOM_ITEMS  = 600;
	localparam int unsigned IDLE_LIMIT    = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;

	// One predicted result item.
	typedef struct {
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  done;
		logic [CNT_W-1:0]  held;
		logic [CNT_W-1:0]  room;
	} fifo_status_t;

	// Shadow ring: tracks pointers and contents, and queues predicted results.
	class ring_fifo_tracker;
		logic [DATA_W-1:0] ring_bytes [RING_BYTES];
		int unsigned       wr_ptr = 0;
		int unsigned       rd_ptr = 0;
		bit                is_empty = 1'b1;
		fifo_status_t      expected_status [$];
		int unsigned       mismatches = 0;

		function int unsigned held_bytes();
			if (wr_ptr > rd_ptr) return wr_ptr - rd_ptr;
			if (wr_ptr < rd_ptr) return RING_BYTES - rd_ptr + wr_ptr;
			return is_empty ? 0 : RING_BYTES;
		endfunction

		function int unsigned advance(int unsigned ptr, int unsigned step);
			int unsigned sum;
			sum = ptr + step;
			if (sum >= RING_BYTES) sum -= RING_BYTES;
			return sum;
		endfunction

		// Executes one command on the shadow ring and queues its result.
		function void apply_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] din,
				logic [CNT_W-1:0] amt);
			int unsigned  held;
			int unsigned  count;
			int unsigned  amt_u;
			fifo_status_t st;
			held    = held_bytes();
			amt_u   = 32'(amt);
			st.data = '0;
			st.done = '0;
			case (cmd_t'(cmd))
				CMD_WRITE: begin
					if (held < RING_BYTES) begin
						ring_bytes[RING_AW'(wr_ptr)] = din;
						wr_ptr   = advance(wr_ptr, 1);
						is_empty = 1'b0;
						st.done  = CNT_W'(1);
					end
				end
				CMD_READ: begin
					if (held > 0) begin
						st.data = ring_bytes[RING_AW'(rd_ptr)];
						rd_ptr  = advance(rd_ptr, 1);
						if (rd_ptr == wr_ptr) is_empty = 1'b1;
						st.done = CNT_W'(1);
					end
				end
				CMD_PEEK: begin
					// The ring is left untouched; offsets past the held bytes give zero.
					if (amt_u < held) begin
						st.data = ring_bytes[RING_AW'(advance(rd_ptr, amt_u))];
						st.done = CNT_W'(1);
					end
				end
				CMD_DROP: begin
					// The count saturates at the held bytes.
					count = (amt_u < held) ? amt_u : held;
					if (count > 0) begin
						rd_ptr = advance(rd_ptr, count);
						if (rd_ptr == wr_ptr) is_empty = 1'b1;
					end
					st.done = CNT_W'(count);
				end
				default: begin
					st.done = '0;
				end
			endcase
			held    = held_bytes();
			st.held = CNT_W'(held);
			st.room = CNT_W'(RING_BYTES - held);
			expected_status.push_back(st);
		endfunction

		function void check_field(string name, logic [CNT_W-1:0] want,
				logic [CNT_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Compares one result item with the oldest prediction.
		function void compare_result(logic [DATA_W-1:0] dout, logic [CNT_W-1:0] done,
				logic [CNT_W-1:0] held, logic [CNT_W-1:0] room);
			fifo_status_t want;
			if (expected_status.size() == 0) begin
				$error("result with no command pending: data_out=%0d done_res=%0d",
					dout, done);
				mismatches++;
				return;
			end
			want = expected_status.pop_front();
			check_field("data_out", CNT_W'(want.data), CNT_W'(dout));
			check_field("done_res", want.done, done);
			check_field("readable", want.held, held);
			check_field("writable", want.room, room);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  command;
	logic [DATA_W-1:0] data_in;
	logic [CNT_W-1:0]  amount;
	logic              strobe;
	logic [DATA_W-1:0] data_out;
	logic [CNT_W-1:0]  done_res;
	logic [CNT_W-1:0]  readable;
	logic [CNT_W-1:0]  writable;

	ring_fifo_tracker  tracker;
	int unsigned       idle_cycles;

	byte_ring_buffer_with_peek_drop_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.data_in  (data_in),
		.amount   (amount),
		.strobe   (strobe),
		.data_out (data_out),
		.done_res (done_res),
		.readable (readable),
		.writable (writable)
	);

	// Clock generation.
	always #5 clk = ~clk;

	// Note each accepted item and check each result at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) tracker.compare_result(data_out, done_res, readable, writable);
			if (start && !busy) tracker.apply_command(command, data_in, amount);
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Presents one item; called just after a falling edge, returns on acceptance.
	task automatic drive_item(cmd_t cmd, logic [DATA_W-1:0] din, logic [CNT_W-1:0] amt);
		start   = 1'b1;
		command = cmd;
		data_in = din;
		amount  = amt;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_command(cmd_t cmd, logic [DATA_W-1:0] din, logic [CNT_W-1:0] amt);
		@(negedge clk);
		drive_item(cmd, din, amt);
	endtask

	task automatic pause_sender(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// Holds off the sender until every predicted result has come back.
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (tracker.expected_status.size() != 0) @(posedge clk);
	endtask

	// Random command, biased toward filling or draining the ring.
	task automatic send_random(bit fill_lean);
		int unsigned      held;
		int unsigned      pick;
		cmd_t             cmd;
		logic [CNT_W-1:0] amt;
		@(negedge clk);
		held = tracker.held_bytes();
		pick = $urandom_range(0, 99);
		amt  = CNT_W'($urandom_range(0, MAX_AMOUNT));
		if (pick < (fill_lean ? 50 : 25)) begin
			cmd = CMD_WRITE;
		end else if (pick < 62) begin
			cmd = CMD_READ;
		end else if (pick < 82) begin
			cmd  = CMD_PEEK;
			pick = $urandom_range(0, 9);
			if (pick < 6 && held > 0) amt = CNT_W'($urandom_range(0, held - 1));
			else if (pick < 8) amt = CNT_W'(held + $urandom_range(0, 2));
		end else begin
			cmd  = CMD_DROP;
			pick = $urandom_range(0, 3);
			if (pick < 2) amt = CNT_W'($urandom_range(0, 4));
			else if (pick == 2) amt = CNT_W'($urandom_range(0, held + 2));
		end
		drive_item(cmd, 8'($urandom_range(0, 255)), amt);
	endtask

	// Main sequence.
	initial begin
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		bit          fill_lean;
		tracker = new;
		clk     = 1'b0;
		arst_n  = 1'b0;
		start   = 1'b0;
		command = CMD_WRITE;
		data_in = '0;
		amount  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Empty ring: read, peek and drop do nothing.
		send_command(CMD_READ, 8'h00, '0);
		send_command(CMD_PEEK, 8'h00, '0);
		send_command(CMD_DROP, 8'h00, '0);
		send_command(CMD_DROP, 8'h00, CNT_W'(MAX_AMOUNT));

		// A few bytes, then peeks inside and past the held region.
		send_command(CMD_WRITE, 8'h00, '0);
		send_command(CMD_WRITE, 8'hFF, CNT_W'(MAX_AMOUNT));
		send_command(CMD_WRITE, 8'h80, '0);
		send_command(CMD_WRITE, 8'h01, '0);
		send_command(CMD_PEEK, 8'h00, CNT_W'(0));
		send_command(CMD_PEEK, 8'h00, CNT_W'(3));
		send_command(CMD_PEEK, 8'h00, CNT_W'(4));
		send_command(CMD_PEEK, 8'hFF, CNT_W'(MAX_AMOUNT));
		send_command(CMD_READ, 8'h00, '0);
		send_command(CMD_DROP, 8'h00, CNT_W'(1));
		send_command(CMD_DROP, 8'h00, CNT_W'(0));
		send_command(CMD_DROP, 8'h00, CNT_W'(RING_BYTES));
		send_command(CMD_READ, 8'h00, '0);

		// Fill to the brim from an offset so that the write pointer wraps.
		repeat (RING_BYTES)
			send_command(CMD_WRITE, 8'($urandom_range(0, 255)),
				CNT_W'($urandom_range(0, MAX_AMOUNT)));

		// Full ring: refused write, zero drop, peeks across the wrap.
		send_command(CMD_WRITE, 8'hAA, '0);
		send_command(CMD_DROP, 8'h00, CNT_W'(0));
		send_command(CMD_PEEK, 8'h00, CNT_W'(RING_BYTES - 1));
		send_command(CMD_PEEK, 8'h00, CNT_W'(RING_BYTES));
		send_command(CMD_READ, 8'h00, '0);
		send_command(CMD_WRITE, 8'h55, '0);
		send_command(CMD_WRITE, 8'h33, '0);
		send_command(CMD_DROP, 8'h00, CNT_W'(RING_BYTES));
		wait_drained();

		// Random bursts with random gaps; now and then let the ring settle.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst     = $urandom_range(1, 40);
			fill_lean = 1'($urandom_range(0, 1));
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				send_random(fill_lean);
				sent++;
			end
			if ($urandom_range(0, 7) == 0) begin
				wait_drained();
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				pause_sender(gap);
			end
		end

		// Let the last results come out, then report.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.expected_status.size() != 0) begin
			$error("%0d results never arrived", tracker.expected_status.size());
			tracker.mismatches++;
		end
		if (tracker.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
